@@ rtl/dfms_pkg.sv @@
// ----------------------------------------------------------------------------
// dfms_pkg
// Shared constants, types and helpers for the decimal field max scanner.
// ----------------------------------------------------------------------------
package dfms_pkg;

    function automatic longint pow10(input int n);
        longint p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

    localparam int INT_BITS    = 24;
    localparam int FRAC_BITS   = 20;
    localparam int FRAC_DIGITS = 6;

    localparam int VAL_W    = INT_BITS + FRAC_BITS;
    localparam int M_DATA_W = ((VAL_W + 7) / 8) * 8;

    localparam longint FRAC_SCALE = pow10(FRAC_DIGITS);
    localparam int     FA_W       = $clog2(FRAC_SCALE);
    localparam int     FD_W       = $clog2(FRAC_DIGITS + 1);

    // reciprocal of the fraction scale, estimate is low by at most one
    localparam int     RECIP_SHIFT = FA_W;
    localparam longint RECIP       = (longint'(1) << (FRAC_BITS + RECIP_SHIFT)) / FRAC_SCALE;
    localparam int     RECIP_W     = FRAC_BITS + 1;
    localparam int     PROD_W      = FA_W + RECIP_W;
    localparam int     X_W         = FA_W + FRAC_BITS;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_F     = 8'h66;

    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic                 commit;
        logic [INT_BITS-1:0]  int_part;
        logic [FA_W-1:0]      frac_acc;
    } field_t;

    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic                 commit;
        logic [VAL_W-1:0]     value;
    } value_t;

endpackage

@@ rtl/dfms_line_parser.sv @@
// ----------------------------------------------------------------------------
// dfms_line_parser
// Input register and per-byte line parser; emits one field word per byte.
// ----------------------------------------------------------------------------
module dfms_line_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic                 s_valid,
    input  logic [7:0]           s_byte,
    input  logic                 s_last,
    output dfms_pkg::field_t     field_o
);

    typedef enum logic [2:0] {
        PH_INT,
        PH_FRAC,
        PH_SKIP,
        PH_WAIT,
        PH_STOP
    } phase_t;

    function automatic logic [dfms_pkg::FA_W-1:0] frac_weight(
        input logic [dfms_pkg::FD_W-1:0] n
    );
        logic [dfms_pkg::FA_W-1:0] w;
        w = '0;
        for (int i = 0; i < dfms_pkg::FRAC_DIGITS; i++) begin
            if (n == dfms_pkg::FD_W'(i)) begin
                w = dfms_pkg::FA_W'(dfms_pkg::pow10(dfms_pkg::FRAC_DIGITS - 1 - i));
            end
        end
        return w;
    endfunction

    logic                            in_valid_reg;
    logic [7:0]                      in_byte_reg;
    logic                            in_last_reg;

    phase_t                          phase_reg, phase_next;
    logic [dfms_pkg::INT_BITS-1:0]   int_acc_reg, int_acc_next;
    logic [dfms_pkg::FA_W-1:0]       frac_acc_reg, frac_acc_next;
    logic [dfms_pkg::FD_W-1:0]       frac_cnt_reg, frac_cnt_next;
    dfms_pkg::field_t                field_reg, field_next;

    logic                            is_digit;
    logic [3:0]                      digit;
    logic [dfms_pkg::INT_BITS+3:0]   int_wide;
    logic [dfms_pkg::FA_W+3:0]       frac_add;

    always_comb begin
        is_digit = (in_byte_reg >= dfms_pkg::CH_ZERO) && (in_byte_reg <= dfms_pkg::CH_NINE);
        digit    = in_byte_reg[3:0];
        int_wide = ((dfms_pkg::INT_BITS+4)'(int_acc_reg) << 3)
                 + ((dfms_pkg::INT_BITS+4)'(int_acc_reg) << 1)
                 + (dfms_pkg::INT_BITS+4)'(digit);
        frac_add = (dfms_pkg::FA_W+4)'(digit) * (dfms_pkg::FA_W+4)'(frac_weight(frac_cnt_reg));

        phase_next    = phase_reg;
        int_acc_next  = int_acc_reg;
        frac_acc_next = frac_acc_reg;
        frac_cnt_next = frac_cnt_reg;

        field_next.valid    = in_valid_reg;
        field_next.last     = in_last_reg;
        field_next.commit   = 1'b0;
        field_next.int_part = int_acc_reg;
        field_next.frac_acc = frac_acc_reg;

        if (in_valid_reg && (phase_reg != PH_STOP)) begin
            priority if (in_byte_reg == dfms_pkg::CH_NUL) begin
                phase_next = PH_STOP;
            end else if ((in_byte_reg == dfms_pkg::CH_CR) || (in_byte_reg == dfms_pkg::CH_LF)) begin
                phase_next    = PH_INT;
                int_acc_next  = '0;
                frac_acc_next = '0;
                frac_cnt_next = '0;
            end else begin
                unique case (phase_reg)
                    PH_INT: begin
                        if (is_digit) begin
                            if (int_wide[dfms_pkg::INT_BITS+3:dfms_pkg::INT_BITS] != '0) begin
                                int_acc_next = '1;
                            end else begin
                                int_acc_next = int_wide[dfms_pkg::INT_BITS-1:0];
                            end
                        end else if (in_byte_reg == dfms_pkg::CH_DOT) begin
                            phase_next = PH_FRAC;
                        end else begin
                            phase_next = PH_WAIT;
                        end
                    end
                    PH_FRAC: begin
                        if (is_digit) begin
                            if (frac_cnt_reg < dfms_pkg::FD_W'(dfms_pkg::FRAC_DIGITS)) begin
                                frac_acc_next = frac_acc_reg + frac_add[dfms_pkg::FA_W-1:0];
                                frac_cnt_next = frac_cnt_reg + 1'b1;
                            end
                        end else if (in_byte_reg == dfms_pkg::CH_F) begin
                            phase_next = PH_SKIP;
                        end else if (in_byte_reg == dfms_pkg::CH_COMMA) begin
                            field_next.commit = 1'b1;
                            phase_next        = PH_WAIT;
                        end else begin
                            phase_next = PH_WAIT;
                        end
                    end
                    PH_SKIP: begin
                        if (in_byte_reg == dfms_pkg::CH_COMMA) begin
                            field_next.commit = 1'b1;
                            phase_next        = PH_WAIT;
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end

        if (in_valid_reg && in_last_reg) begin
            phase_next    = PH_INT;
            int_acc_next  = '0;
            frac_acc_next = '0;
            frac_cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            phase_reg       <= PH_INT;
            int_acc_reg     <= '0;
            frac_acc_reg    <= '0;
            frac_cnt_reg    <= '0;
            field_reg.valid <= 1'b0;
        end else if (advance) begin
            in_valid_reg <= s_valid;
            in_byte_reg  <= s_byte;
            in_last_reg  <= s_last;
            phase_reg    <= phase_next;
            int_acc_reg  <= int_acc_next;
            frac_acc_reg <= frac_acc_next;
            frac_cnt_reg <= frac_cnt_next;
            field_reg    <= field_next;
        end
    end

    assign field_o = field_reg;

endmodule

@@ rtl/dfms_frac_scaler.sv @@
// ----------------------------------------------------------------------------
// dfms_frac_scaler
// Converts the decimal fraction to binary by reciprocal multiply and fix-up.
// ----------------------------------------------------------------------------
module dfms_frac_scaler (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  dfms_pkg::field_t     field_i,
    output dfms_pkg::value_t     value_o
);

    localparam logic [dfms_pkg::RECIP_W-1:0] RECIP_V = dfms_pkg::RECIP_W'(dfms_pkg::RECIP);
    localparam logic [dfms_pkg::X_W-1:0]     SCALE_V = dfms_pkg::X_W'(dfms_pkg::FRAC_SCALE);

    dfms_pkg::field_t                 c_reg;
    logic [dfms_pkg::PROD_W-1:0]      prod_reg, prod_next;
    dfms_pkg::field_t                 d_reg;
    logic [dfms_pkg::FRAC_BITS-1:0]   qe_reg, qe_next;
    logic [dfms_pkg::X_W-1:0]         back_reg, back_next;
    dfms_pkg::value_t                 value_reg, value_next;

    logic [dfms_pkg::X_W-1:0]         x_shift;
    logic [dfms_pkg::X_W-1:0]         rem;
    logic [dfms_pkg::FRAC_BITS-1:0]   q_frac;

    always_comb begin
        prod_next = dfms_pkg::PROD_W'(field_i.frac_acc) * dfms_pkg::PROD_W'(RECIP_V);
        qe_next   = prod_reg[dfms_pkg::RECIP_SHIFT +: dfms_pkg::FRAC_BITS];
        back_next = dfms_pkg::X_W'(qe_next) * SCALE_V;

        x_shift = {d_reg.frac_acc, {dfms_pkg::FRAC_BITS{1'b0}}};
        rem     = x_shift - back_reg;
        q_frac  = qe_reg + dfms_pkg::FRAC_BITS'(rem >= SCALE_V);

        value_next.valid  = d_reg.valid;
        value_next.last   = d_reg.last;
        value_next.commit = d_reg.commit;
        value_next.value  = {d_reg.int_part, q_frac};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_reg.valid     <= 1'b0;
            d_reg.valid     <= 1'b0;
            value_reg.valid <= 1'b0;
        end else if (advance) begin
            c_reg     <= field_i;
            prod_reg  <= prod_next;
            d_reg     <= c_reg;
            qe_reg    <= qe_next;
            back_reg  <= back_next;
            value_reg <= value_next;
        end
    end

    assign value_o = value_reg;

endmodule

@@ rtl/dfms_max_tracker.sv @@
// ----------------------------------------------------------------------------
// dfms_max_tracker
// Keeps the running maximum and holds the result word for the output side.
// ----------------------------------------------------------------------------
module dfms_max_tracker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dfms_pkg::value_t              value_i,
    input  logic                          m_ready,
    output logic                          advance,
    output logic                          m_valid,
    output logic [dfms_pkg::VAL_W-1:0]    m_max,
    output logic                          m_found
);

    logic [dfms_pkg::VAL_W-1:0]  max_reg, max_next;
    logic                        out_valid_reg;
    logic [dfms_pkg::VAL_W-1:0]  out_max_reg;
    logic                        out_found_reg;
    logic [dfms_pkg::VAL_W-1:0]  new_max;
    logic                        load;

    always_comb begin
        advance = !(value_i.valid && value_i.last && out_valid_reg && !m_ready);
        load    = advance && value_i.valid;
        if (value_i.commit && (value_i.value > max_reg)) begin
            new_max = value_i.value;
        end else begin
            new_max = max_reg;
        end
        max_next = value_i.last ? '0 : new_max;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                max_reg <= max_next;
            end
            if (load && value_i.last) begin
                out_valid_reg <= 1'b1;
                out_max_reg   <= new_max;
                out_found_reg <= (new_max != '0);
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_max   = out_max_reg;
    assign m_found = out_found_reg;

    a_max_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !value_i.last) |=> (max_reg >= $past(max_reg)))
        else $error("running max dropped within a buffer");

    a_max_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && value_i.last) |=> (max_reg == '0))
        else $error("running max not cleared after last word");

    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |-> out_valid_reg)
        else $error("pipeline stalled with empty output register");

endmodule

@@ rtl/decimal_field_max_scanner_unit.sv @@
// ----------------------------------------------------------------------------
// decimal_field_max_scanner_unit
// Scans text one byte per word and reports the largest decimal first field.
// ----------------------------------------------------------------------------
// Result path: parser input and field regs, scaler c, d, value regs, output reg.
// Throughput: one byte per cycle; input stalls only while a finished result
//   waits at the output and a second tlast word has reached the last stage.
// Reset: synchronous aresetn clears all stage valids, parser state and max.
// ----------------------------------------------------------------------------
module decimal_field_max_scanner_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] data_byte
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dfms_pkg::M_DATA_W-1:0]   m_tdata,   // [43:0] max_value, zero pad
    output logic                            m_tuser    // [0] found
);

    logic                         advance;
    dfms_pkg::field_t             field;
    dfms_pkg::value_t             value;
    logic [dfms_pkg::VAL_W-1:0]   max_value;

    dfms_line_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .s_valid (s_tvalid),
        .s_byte  (s_tdata),
        .s_last  (s_tlast),
        .field_o (field)
    );

    dfms_frac_scaler u_scaler (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .field_i (field),
        .value_o (value)
    );

    dfms_max_tracker u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .value_i (value),
        .m_ready (m_tready),
        .advance (advance),
        .m_valid (m_tvalid),
        .m_max   (max_value),
        .m_found (m_tuser)
    );

    assign s_tready = advance;
    assign m_tdata  = dfms_pkg::M_DATA_W'(max_value);

endmodule
